[rtl/rcr_pkg.sv]
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared types, register indexes and helpers for the ray / cylinder root
// pipeline.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_AXIS_PX,
    REG_AXIS_PY,
    REG_AXIS_PZ,
    REG_AXIS_DX,
    REG_AXIS_DY,
    REG_AXIS_DZ,
    REG_RADIUS
  } reg_idx_t;

  localparam logic signed [17:0] AXIS_DZ_RESET = 18'sd65536;
  localparam logic [30:0]        RADIUS_RESET  = 31'd65536;

  // Cylinder description, held in the configuration registers.
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [17:0] dz;
    logic [30:0]        radius;
  } cyl_t;

  // Quadratic terms: a = nv.nv, p = nv.nu, disc = p^2 - a*c.
  typedef struct packed {
    logic               miss;
    logic signed [64:0] p;
    logic [63:0]        a;
    logic [127:0]       disc;
  } quad_t;

  // Inputs to the root dividers, s = floor(sqrt(disc)).
  typedef struct packed {
    logic               miss;
    logic signed [64:0] p;
    logic [63:0]        a;
    logic [63:0]        s;
  } rootin_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

[rtl/rcr_quad.sv]
// ----------------------------------------------------------------------------
// rcr_quad
// Ten-stage front end: removes the axis-parallel parts of the ray direction
// and of the origin offset, then forms a, p = b/2 and the discriminant.
// ----------------------------------------------------------------------------
module rcr_quad
  import rcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] ray_dir_x,
  input  logic signed [31:0] ray_dir_y,
  input  logic signed [31:0] ray_dir_z,
  input  cyl_t               cyl,
  output logic               res_valid,
  input  logic               res_ready,
  output quad_t              res
);

  localparam int NS = 10;

  logic [NS:1]   v;
  logic [NS:1]   vprev;
  logic [NS+1:1] adv;

  logic signed [31:0] org [3];
  logic signed [31:0] rdir [3];
  logic signed [31:0] ap [3];
  logic signed [17:0] ad [3];

  logic signed [32:0] s1_wu [3];
  logic signed [31:0] s1_wv [3];
  logic signed [32:0] s2_wu [3];
  logic signed [31:0] s2_wv [3];
  logic signed [52:0] s2_du;
  logic signed [52:0] s2_dv;
  logic signed [32:0] s3_wu [3];
  logic signed [31:0] s3_wv [3];
  logic signed [61:0] s3_pu [3];
  logic signed [61:0] s3_pv [3];
  logic signed [31:0] s4_nu [3];
  logic signed [31:0] s4_nv [3];
  logic [63:0]        s5_vv [3];
  logic [63:0]        s5_uu [3];
  logic signed [63:0] s5_vu [3];
  logic [63:0]        s6_a;
  logic [63:0]        s6_su;
  logic signed [64:0] s6_p;
  logic [61:0]        s6_r2;
  logic signed [65:0] s6_diff;
  logic [63:0]        s7_a;
  logic signed [64:0] s7_p;
  logic               s7_cneg;
  logic [63:0]        s7_e;
  logic [63:0]        s7_hm;
  logic [63:0]        s8_a;
  logic signed [64:0] s8_p;
  logic               s8_cneg;
  logic [63:0]        s8_hll;
  logic [63:0]        s8_hlh;
  logic [63:0]        s8_hhh;
  logic [63:0]        s8_all;
  logic [63:0]        s8_alh;
  logic [63:0]        s8_ahl;
  logic [63:0]        s8_ahh;
  logic [63:0]        s9_a;
  logic signed [64:0] s9_p;
  logic               s9_cneg;
  logic [127:0]       s9_hsq;
  logic [127:0]       s9_ac;
  quad_t              s10;

  // Parallel part of one component: floor(d * k / 2^F).
  function automatic logic signed [61:0] par_of(input logic signed [17:0] d,
                                               input logic signed [52:0] k);
    logic signed [70:0] pr;
    pr = 71'(d) * 71'(k);
    return 62'(pr >>> FRAC_BITS);
  endfunction

  assign org[0]  = origin_x;
  assign org[1]  = origin_y;
  assign org[2]  = origin_z;
  assign rdir[0] = ray_dir_x;
  assign rdir[1] = ray_dir_y;
  assign rdir[2] = ray_dir_z;
  assign ap[0]   = cyl.px;
  assign ap[1]   = cyl.py;
  assign ap[2]   = cyl.pz;
  assign ad[0]   = cyl.dx;
  assign ad[1]   = cyl.dy;
  assign ad[2]   = cyl.dz;

  // A stage moves on when it is empty or the next one moves on.
  assign adv[NS+1] = res_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign vprev     = {v[NS-1:1], valid};
  assign ready     = adv[1];
  assign res_valid = v[NS];
  assign res       = s10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= vprev[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_wu[i] <= 33'(org[i]) - 33'(ap[i]);
        s1_wv[i] <= rdir[i];
      end
    end
    if (adv[2]) begin
      s2_wu <= s1_wu;
      s2_wv <= s1_wv;
      s2_du <= 53'(s1_wu[0] * ad[0]) + 53'(s1_wu[1] * ad[1]) + 53'(s1_wu[2] * ad[2]);
      s2_dv <= 53'(s1_wv[0] * ad[0]) + 53'(s1_wv[1] * ad[1]) + 53'(s1_wv[2] * ad[2]);
    end
    if (adv[3]) begin
      s3_wu <= s2_wu;
      s3_wv <= s2_wv;
      for (int i = 0; i < 3; i++) begin
        s3_pu[i] <= par_of(ad[i], s2_du >>> FRAC_BITS);
        s3_pv[i] <= par_of(ad[i], s2_dv >>> FRAC_BITS);
      end
    end
    if (adv[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_nu[i] <= sat32(64'(s3_wu[i]) - 64'(s3_pu[i]));
        s4_nv[i] <= sat32(64'(s3_wv[i]) - 64'(s3_pv[i]));
      end
    end
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        s5_vv[i] <= 64'(s4_nv[i] * s4_nv[i]);
        s5_uu[i] <= 64'(s4_nu[i] * s4_nu[i]);
        s5_vu[i] <= 64'(s4_nv[i] * s4_nu[i]);
      end
    end
    if (adv[6]) begin
      s6_a  <= s5_vv[0] + s5_vv[1] + s5_vv[2];
      s6_su <= s5_uu[0] + s5_uu[1] + s5_uu[2];
      s6_p  <= 65'(s5_vu[0]) + 65'(s5_vu[1]) + 65'(s5_vu[2]);
      s6_r2 <= 62'(cyl.radius * cyl.radius);
    end
    if (adv[7]) begin
      s7_a    <= s6_a;
      s7_p    <= s6_p;
      s7_cneg <= s6_diff[65];
      s7_e    <= s6_diff[65] ? 64'(-s6_diff) : s6_diff[63:0];
      s7_hm   <= s6_p[64] ? 64'(-s6_p) : s6_p[63:0];
    end
    // The two 64 x 64 products are split into 32 x 32 partial products.
    if (adv[8]) begin
      s8_a    <= s7_a;
      s8_p    <= s7_p;
      s8_cneg <= s7_cneg;
      s8_hll  <= 64'(s7_hm[31:0] * s7_hm[31:0]);
      s8_hlh  <= 64'(s7_hm[31:0] * s7_hm[63:32]);
      s8_hhh  <= 64'(s7_hm[63:32] * s7_hm[63:32]);
      s8_all  <= 64'(s7_a[31:0] * s7_e[31:0]);
      s8_alh  <= 64'(s7_a[31:0] * s7_e[63:32]);
      s8_ahl  <= 64'(s7_a[63:32] * s7_e[31:0]);
      s8_ahh  <= 64'(s7_a[63:32] * s7_e[63:32]);
    end
    if (adv[9]) begin
      s9_a    <= s8_a;
      s9_p    <= s8_p;
      s9_cneg <= s8_cneg;
      s9_hsq  <= {s8_hhh, s8_hll} + {31'b0, s8_hlh, 33'b0};
      s9_ac   <= {s8_ahh, s8_all} + {32'b0, s8_alh, 32'b0} + {32'b0, s8_ahl, 32'b0};
    end
    if (adv[10]) begin
      s10.a    <= s9_a;
      s10.p    <= s9_p;
      s10.miss <= (s9_a == '0) || (!s9_cneg && (s9_hsq < s9_ac));
      s10.disc <= s9_cneg ? s9_hsq + s9_ac : s9_hsq - s9_ac;
    end
  end

  // c = nu.nu - r^2, kept as sign and magnitude.
  assign s6_diff = $signed({2'b00, s6_su}) - $signed({4'b0000, s6_r2});

`ifndef ASSERT_OFF
  a_parallel_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.a == '0) |-> res.miss)
    else $error("parallel ray not flagged as miss");
`endif

endmodule

[rtl/rcr_sqrt.sv]
// ----------------------------------------------------------------------------
// rcr_sqrt
// Integer square root of the 128-bit discriminant, one result bit per
// pipeline stage (64 stages), restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module rcr_sqrt
  import rcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    valid,
  output logic    ready,
  input  quad_t   quad,
  output logic    res_valid,
  input  logic    res_ready,
  output rootin_t res
);

  localparam int NS = 64;

  typedef struct packed {
    logic [64:0]        rem;
    logic [63:0]        root;
    logic [127:0]       disc;
    logic               miss;
    logic signed [64:0] p;
    logic [63:0]        a;
  } sq_stage_t;

  logic [NS:1]   v;
  logic [NS:1]   vprev;
  logic [NS+1:1] adv;
  sq_stage_t     src [1:NS];
  sq_stage_t     st  [1:NS];

  assign adv[NS+1] = res_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign vprev     = {v[NS-1:1], valid};
  assign ready     = adv[1];
  assign res_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= vprev[k];
        end
      end
    end
  end

  assign src[1] = '{rem: '0, root: '0, disc: quad.disc, miss: quad.miss,
                    p: quad.p, a: quad.a};

  for (genvar i = 1; i <= NS; i++) begin : g_stage
    localparam int J = NS - i;
    logic [66:0] rem_sh;
    logic [65:0] trial;
    logic        ge;

    if (i > 1) begin : g_link
      assign src[i] = st[i-1];
    end

    // Bring down the next two bits and try appending a one to the root.
    assign rem_sh = {src[i].rem, src[i].disc[2*J+1:2*J]};
    assign trial  = {src[i].root, 2'b01};
    assign ge     = rem_sh >= {1'b0, trial};

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        st[i].disc <= src[i].disc;
        st[i].miss <= src[i].miss;
        st[i].p    <= src[i].p;
        st[i].a    <= src[i].a;
        st[i].rem  <= ge ? 65'(rem_sh - {1'b0, trial}) : rem_sh[64:0];
        st[i].root <= {src[i].root[62:0], ge};
      end
    end
  end

  assign res.miss = st[NS].miss;
  assign res.p    = st[NS].p;
  assign res.a    = st[NS].a;
  assign res.s    = st[NS].root;

endmodule

[rtl/rcr_div.sv]
// ----------------------------------------------------------------------------
// rcr_div
// Forms both root numerators, divides each by a with a 33-stage restoring
// divider and saturates the quotients to 32 bits.
// ----------------------------------------------------------------------------
module rcr_div
  import rcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  rootin_t            rin,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               hit,
  output logic signed [31:0] t_near,
  output logic signed [31:0] t_far
);

  localparam int NS = 35;
  localparam int NW = 66 + FRAC_BITS;

  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] nlo;
    logic [32:0] q;
    logic        ovf;
    logic        neg;
  } dlane_t;

  typedef struct packed {
    dlane_t      ln;
    dlane_t      lf;
    logic [63:0] a;
    logic        miss;
  } dv_t;

  logic [NS:1]        v;
  logic [NS:1]        vprev;
  logic [NS+1:1]      adv;
  dv_t                st [1:NS-1];
  logic signed [66:0] vn;
  logic signed [66:0] vf;

  // Numerator scaled by 2^F. A quotient of 2^33 or more always saturates,
  // so only the low 33 quotient bits are worked out.
  function automatic dlane_t prep_lane(input logic signed [66:0] x,
                                       input logic [63:0] a);
    logic [65:0]   m;
    logic [NW-1:0] num;
    dlane_t        r;
    m     = x[66] ? 66'(-x) : x[65:0];
    num   = {m, {FRAC_BITS{1'b0}}};
    r.neg = x[66];
    r.ovf = 64'(num[NW-1:33]) >= a;
    r.rem = 64'(num[NW-1:33]);
    r.nlo = num[32:0];
    r.q   = '0;
    return r;
  endfunction

  function automatic dlane_t step_lane(input dlane_t l, input logic [63:0] a,
                                       input logic nbit);
    logic [64:0] sh;
    logic        ge;
    dlane_t      r;
    r     = l;
    sh    = {l.rem, nbit};
    ge    = sh >= {1'b0, a};
    r.rem = ge ? 64'(sh - {1'b0, a}) : sh[63:0];
    r.q   = {l.q[31:0], ge};
    return r;
  endfunction

  function automatic logic signed [31:0] fin_lane(input dlane_t l);
    if (l.neg) begin
      if (l.ovf || (l.q > 33'h0_8000_0000)) begin
        return 32'h8000_0000;
      end
      return 32'(33'd0 - l.q);
    end
    if (l.ovf || (l.q > 33'h0_7fff_ffff)) begin
      return 32'h7fff_ffff;
    end
    return l.q[31:0];
  endfunction

  assign adv[NS+1] = res_ready;
  for (genvar k = 1; k <= NS; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign vprev     = {v[NS-1:1], valid};
  assign ready     = adv[1];
  assign res_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= vprev[k];
        end
      end
    end
  end

  // Roots are (-p - s) / a and (-p + s) / a.
  assign vn = -67'(rin.p) - $signed({3'b000, rin.s});
  assign vf = -67'(rin.p) + $signed({3'b000, rin.s});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      st[1].ln   <= prep_lane(vn, rin.a);
      st[1].lf   <= prep_lane(vf, rin.a);
      st[1].a    <= rin.a;
      st[1].miss <= rin.miss;
    end
  end

  for (genvar k = 2; k <= NS - 1; k++) begin : g_step
    localparam int B = NS - 1 - k;
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st[k].ln   <= step_lane(st[k-1].ln, st[k-1].a, st[k-1].ln.nlo[B]);
        st[k].lf   <= step_lane(st[k-1].lf, st[k-1].a, st[k-1].lf.nlo[B]);
        st[k].a    <= st[k-1].a;
        st[k].miss <= st[k-1].miss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      hit    <= !st[NS-1].miss;
      t_near <= st[NS-1].miss ? '0 : fin_lane(st[NS-1].ln);
      t_far  <= st[NS-1].miss ? '0 : fin_lane(st[NS-1].lf);
    end
  end

endmodule

[rtl/ray_cylinder_roots.sv]
// ----------------------------------------------------------------------------
// ray_cylinder_roots
// Ray against infinite cylinder: both roots of the intersection quadratic.
// ----------------------------------------------------------------------------
// The block takes one ray per clock while the output keeps up and returns one
// result per ray, in order, through ten stages of projection and quadratic
// setup, 64 stages of square root (one root bit per stage) and 35 stages of
// root division (one quotient bit per stage plus setup and saturation). A
// stalled output holds its beat and the stall spreads back stage by stage, so
// empty stages still fill while the output waits. Cylinder registers are
// written through the cfg port, which is always ready; write them only while
// no ray is in flight.
module ray_cylinder_roots
  import rcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               ray_valid,
  output logic               ray_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] ray_dir_x,
  input  logic signed [31:0] ray_dir_y,
  input  logic signed [31:0] ray_dir_z,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               hit,
  output logic signed [31:0] t_near,
  output logic signed [31:0] t_far
);

  cyl_t    cyl;
  quad_t   quad;
  rootin_t rin;
  logic    quad_valid;
  logic    quad_ready;
  logic    rin_valid;
  logic    rin_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cyl.px     <= '0;
      cyl.py     <= '0;
      cyl.pz     <= '0;
      cyl.dx     <= '0;
      cyl.dy     <= '0;
      cyl.dz     <= AXIS_DZ_RESET;
      cyl.radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AXIS_PX: cyl.px     <= cfg_data;
        REG_AXIS_PY: cyl.py     <= cfg_data;
        REG_AXIS_PZ: cyl.pz     <= cfg_data;
        REG_AXIS_DX: cyl.dx     <= cfg_data[17:0];
        REG_AXIS_DY: cyl.dy     <= cfg_data[17:0];
        REG_AXIS_DZ: cyl.dz     <= cfg_data[17:0];
        REG_RADIUS:  cyl.radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rcr_quad #(
    .FRAC_BITS(FRAC_BITS)
  ) u_quad (
    .clk      (clk),
    .rst      (rst),
    .valid    (ray_valid),
    .ready    (ray_ready),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .ray_dir_x(ray_dir_x),
    .ray_dir_y(ray_dir_y),
    .ray_dir_z(ray_dir_z),
    .cyl      (cyl),
    .res_valid(quad_valid),
    .res_ready(quad_ready),
    .res      (quad)
  );

  rcr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .valid    (quad_valid),
    .ready    (quad_ready),
    .quad     (quad),
    .res_valid(rin_valid),
    .res_ready(rin_ready),
    .res      (rin)
  );

  rcr_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .valid    (rin_valid),
    .ready    (rin_ready),
    .rin      (rin),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .hit      (hit),
    .t_near   (t_near),
    .t_far    (t_far)
  );

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !hit |-> (t_near == '0) && (t_far == '0))
    else $error("miss beat carries nonzero roots");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && hit |-> t_near <= t_far)
    else $error("near root lies beyond far root");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams rays into ray_cylinder_roots under several cylinder settings and
// compares every result beat with roots computed in exact wide arithmetic.
// ----------------------------------------------------------------------------
module testbench
  import rcr_pkg::*;
;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] tn, tf;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic ray_valid = 1'b0;
  logic ray_ready;
  logic res_valid;
  logic res_ready = 1'b0;
  logic hit;
  logic signed [31:0] t_near, t_far;

  ray_t cur_ray = '0;
  ray_t pending_rays[$];
  roots_t expected_roots[$];
  logic [31:0] cyl_reg[7];
  int send_gap = 0;
  int recv_stall = 0;
  bit no_idle = 1'b0;
  int errors = 0;

  ray_cylinder_roots u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_ready(ray_ready),
    .origin_x(cur_ray.ox), .origin_y(cur_ray.oy), .origin_z(cur_ray.oz),
    .ray_dir_x(cur_ray.dx), .ray_dir_y(cur_ray.dy), .ray_dir_z(cur_ray.dz),
    .res_valid(res_valid), .res_ready(res_ready),
    .hit(hit), .t_near(t_near), .t_far(t_far)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > longint'(SMAX)) return longint'(SMAX);
    if (x < longint'(SMIN)) return longint'(SMIN);
    return x;
  endfunction

  // Removes the part of w along d; k is floored, as is each parallel part.
  function automatic void strip_axis(input longint w[3], input longint d[3],
                                     output longint o[3]);
    longint dot, k;
    dot = w[0] * d[0] + w[1] * d[1] + w[2] * d[2];
    k = dot >>> FRAC;
    for (int i = 0; i < 3; i++) o[i] = clamp32(w[i] - ((d[i] * k) >>> FRAC));
  endfunction

  function automatic logic signed [31:0] scaled_root(input logic signed [129:0] v,
                                                     input logic signed [129:0] a);
    logic signed [129:0] mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag <<< FRAC) / a;
    if (v < 0) return (q > 130'sd2147483648) ? SMIN : 32'(-q);
    return (q > 130'sd2147483647) ? SMAX : 32'(q);
  endfunction

  function automatic roots_t solve_ray(input ray_t r);
    longint off[3], dir[3], ax[3], nv[3], nu[3];
    logic signed [129:0] x, y, h, a, c, disc, cand, sq, rad;
    roots_t res;
    off[0] = longint'(r.ox) - longint'($signed(cyl_reg[REG_AXIS_PX]));
    off[1] = longint'(r.oy) - longint'($signed(cyl_reg[REG_AXIS_PY]));
    off[2] = longint'(r.oz) - longint'($signed(cyl_reg[REG_AXIS_PZ]));
    dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
    for (int i = 0; i < 3; i++) ax[i] = longint'($signed(cyl_reg[REG_AXIS_DX + i][17:0]));
    strip_axis(dir, ax, nv);
    strip_axis(off, ax, nu);
    h = 0; a = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      x = nv[i];
      y = nu[i];
      h += x * y;
      a += x * x;
      c += y * y;
    end
    rad = {99'd0, cyl_reg[REG_RADIUS][30:0]};
    c -= rad * rad;
    res = '0;
    if (a == 0) return res;
    disc = h * h - a * c;
    if (disc < 0) return res;
    sq = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = sq | (130'sd1 <<< b);
      if (cand * cand <= disc) sq = cand;
    end
    res.hit = 1'b1;
    res.tn = scaled_root(-h - sq, a);
    res.tf = scaled_root(-h + sq, a);
    return res;
  endfunction

  // Register shadow follows every accepted configuration beat.
  always @(posedge clk) begin
    if (rst) begin
      cyl_reg[REG_AXIS_PX] <= '0;
      cyl_reg[REG_AXIS_PY] <= '0;
      cyl_reg[REG_AXIS_PZ] <= '0;
      cyl_reg[REG_AXIS_DX] <= '0;
      cyl_reg[REG_AXIS_DY] <= '0;
      cyl_reg[REG_AXIS_DZ] <= 32'(AXIS_DZ_RESET);
      cyl_reg[REG_RADIUS] <= 32'(RADIUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS_PX, REG_AXIS_PY, REG_AXIS_PZ: cyl_reg[cfg_index] <= cfg_data;
        REG_AXIS_DX, REG_AXIS_DY, REG_AXIS_DZ: begin
          cyl_reg[cfg_index] <= {14'd0, cfg_data[17:0]};
        end
        REG_RADIUS: cyl_reg[cfg_index] <= {1'b0, cfg_data[30:0]};
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      ray_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (ray_valid && ray_ready) expected_roots.push_back(solve_ray(cur_ray));
      if (!ray_valid || ray_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          ray_valid <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          cur_ray <= pending_rays.pop_front();
          ray_valid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 4);
        end else begin
          ray_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    int nstall;
    roots_t want;
    if (rst) begin
      res_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with no ray outstanding");
          errors++;
        end else begin
          want = expected_roots.pop_front();
          if (hit !== want.hit) begin
            $error("hit expected %0d got %0d", want.hit, hit);
            errors++;
          end
          if (t_near !== want.tn) begin
            $error("t_near expected %0d got %0d", want.tn, t_near);
            errors++;
          end
          if (t_far !== want.tf) begin
            $error("t_far expected %0d got %0d", want.tf, t_far);
            errors++;
          end
        end
      end
      if (res_valid && res_ready && !no_idle) nstall = $urandom_range(0, 4);
      else nstall = (recv_stall > 0) ? recv_stall - 1 : 0;
      recv_stall <= nstall;
      res_ready <= (nstall == 0);
    end
  end

  task automatic push_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    pending_rays.push_back(r);
  endtask

  // The pipeline is 109 deep; wait until every queued ray has returned its result.
  task automatic wait_idle();
    while (pending_rays.size() != 0 || ray_valid || expected_roots.size() != 0) begin
      @(posedge clk);
    end
    repeat (130) @(posedge clk);
  endtask

  // Call synchronously to clk; the caller drops cfg_valid after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_cylinder(input logic signed [31:0] px, py, pz,
                                input logic signed [17:0] dx, dy, dz,
                                input logic [30:0] radius);
    write_reg(REG_AXIS_PX, px);
    write_reg(REG_AXIS_PY, py);
    write_reg(REG_AXIS_PZ, pz);
    write_reg(REG_AXIS_DX, {14'($urandom_range(0, 16383)), dx});
    write_reg(REG_AXIS_DY, {14'($urandom_range(0, 16383)), dy});
    write_reg(REG_AXIS_DZ, {14'($urandom_range(0, 16383)), dz});
    write_reg(REG_RADIUS, {1'($urandom_range(0, 1)), radius});
    write_reg(REG_UNUSED, $urandom());
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [17:0] axis_comp();
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic signed [31:0] near_val(input logic signed [31:0] base,
                                                  input int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_rays(input int count);
    logic signed [31:0] p[3];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        for (int i = 0; i < 3; i++) p[i] = near_val(cyl_reg[i], 4 * ONE);
        push_ray(p[0], p[1], p[2], near_val(0, 2 * ONE), near_val(0, 2 * ONE),
                 near_val(0, 2 * ONE));
      end
    end
  endtask

  initial begin
    logic signed [17:0] ad[3];
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset cylinder: unit radius around the z axis.
    push_ray(0, 0, 0, ONE, 0, 0);
    push_ray(0, 0, 0, 0, 0, ONE);
    push_ray(0, 3 * ONE, 0, ONE, 0, 0);
    push_ray(-2 * ONE, ONE, 0, ONE, 0, 0);
    push_ray(0, 0, 0, 1, 0, 0);
    push_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
    push_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    push_ray(SMAX, SMIN, 0, SMIN, SMAX, -1);
    push_ray(ONE / 2, 0, 5 * ONE, -ONE, -ONE, 3 * ONE);
    push_ray(0, 0, 0, 0, 0, 0);
    wait_idle();

    write_cylinder(SMIN, SMAX, SMIN, -18'sd65536, 0, 0, 31'h7fff_ffff);
    push_ray(0, 0, 0, 0, ONE, 0);
    push_ray(SMAX, SMIN, SMAX, ONE, 0, 0);
    push_ray(0, 0, 0, 0, 1, 1);
    push_ray(SMIN, SMAX, SMIN, 3, -7, 1);
    wait_idle();

    write_cylinder(SMAX, SMIN, SMAX, 18'sd3000, 18'sd40000, -18'sd65536, 31'd0);
    push_ray(SMAX, SMIN, SMAX, ONE, 0, 0);
    push_ray(SMAX - 5, SMIN + 9, SMAX, 0, ONE, ONE);
    push_ray(0, 0, 0, ONE, ONE, ONE);
    push_ray(SMAX, SMIN, SMAX, 3000, 40000, -65536);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        ad[0] = 0; ad[1] = 0; ad[2] = 0;
        ad[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
      end else begin
        for (int i = 0; i < 3; i++) ad[i] = axis_comp();
      end
      write_cylinder($urandom_range(0, 1) ? $urandom() : near_val(0, 8 * ONE),
                     $urandom_range(0, 1) ? $urandom() : near_val(0, 8 * ONE),
                     $urandom_range(0, 1) ? $urandom() : near_val(0, 8 * ONE),
                     ad[0], ad[1], ad[2],
                     $urandom_range(0, 3) == 0 ? 31'($urandom()) :
                       31'($urandom_range(ONE / 4, 4 * ONE)));
      no_idle = (phase % 4 == 3);
      random_rays(55);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS ray_cylinder_roots");
    end else begin
      $display("FAIL ray_cylinder_roots");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL ray_cylinder_roots");
    $finish;
  end

endmodule
